[src/dpiq_pkg.sv]
// ----------------------------------------------------------------------------
// dpiq_pkg
// Shared types and constants of the delayed packet impairment queue.
// ----------------------------------------------------------------------------
package dpiq_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_EN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER    = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_DELIVERED = 2'd0;
    localparam logic [1:0] KIND_QUEUED    = 2'd1;
    localparam logic [1:0] KIND_DROPPED   = 2'd2;
    localparam logic [1:0] KIND_REJECTED  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_FREE,
        S_WALK,
        S_LINK,
        S_FIX,
        S_TCHK,
        S_TEND
    } t_state;

    typedef struct packed {
        logic load_in;
        logic out_bypass;
        logic out_drop;
        logic out_reject;
        logic start_ins;
        logic free_adv;
        logic walk_adv;
        logic ins_link;
        logic ins_fix;
        logic tick_start;
        logic pop;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic bypass;
        logic drop;
        logic full;
        logic frozen;
        logic out_vld;
        logic head_none;
        logic walk_stop;
        logic link_none;
        logic due_ok;
        logic hold_vld;
        logic pop_last;
    } t_sts;

    // a is after b in wrap-aware time
    function automatic logic is_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

[src/dpiq_ctrl.sv]
// ----------------------------------------------------------------------------
// dpiq_ctrl
// Sequencer for arrive and tick items: decides, walks, links, drains.
// ----------------------------------------------------------------------------
module dpiq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dpiq_pkg::t_sts  i_sts,
    output dpiq_pkg::t_cmd  o_cmd
);

    dpiq_pkg::t_state r_state;
    dpiq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpiq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpiq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = dpiq_pkg::S_DECIDE;
            end
            dpiq_pkg::S_DECIDE: begin
                if (i_sts.is_tick) begin
                    if (i_sts.frozen || i_sts.head_none) n_state = dpiq_pkg::S_IDLE;
                    else n_state = dpiq_pkg::S_TCHK;
                end else if (i_sts.bypass || i_sts.drop || i_sts.full) begin
                    if (!i_sts.out_vld) n_state = dpiq_pkg::S_IDLE;
                end else begin
                    n_state = dpiq_pkg::S_FREE;
                end
            end
            dpiq_pkg::S_FREE: begin
                if (i_sts.head_none) n_state = dpiq_pkg::S_LINK;
                else n_state = dpiq_pkg::S_WALK;
            end
            dpiq_pkg::S_WALK: begin
                if (i_sts.walk_stop || i_sts.link_none) n_state = dpiq_pkg::S_LINK;
            end
            dpiq_pkg::S_LINK: n_state = dpiq_pkg::S_FIX;
            dpiq_pkg::S_FIX: begin
                if (!i_sts.out_vld) n_state = dpiq_pkg::S_IDLE;
            end
            dpiq_pkg::S_TCHK: begin
                if (i_sts.due_ok) begin
                    if (!(i_sts.hold_vld && i_sts.out_vld) && i_sts.pop_last)
                        n_state = dpiq_pkg::S_TEND;
                end else if (!i_sts.hold_vld || !i_sts.out_vld) begin
                    n_state = dpiq_pkg::S_IDLE;
                end
            end
            dpiq_pkg::S_TEND: begin
                if (!i_sts.out_vld) n_state = dpiq_pkg::S_IDLE;
            end
            default: n_state = dpiq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dpiq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            dpiq_pkg::S_DECIDE: begin
                if (i_sts.is_tick) begin
                    o_cmd.tick_start = !(i_sts.frozen || i_sts.head_none);
                end else if (i_sts.bypass) begin
                    o_cmd.out_bypass = !i_sts.out_vld;
                end else if (i_sts.drop) begin
                    o_cmd.out_drop = !i_sts.out_vld;
                end else if (i_sts.full) begin
                    o_cmd.out_reject = !i_sts.out_vld;
                end else begin
                    o_cmd.start_ins = 1'b1;
                end
            end
            dpiq_pkg::S_FREE:  o_cmd.free_adv = 1'b1;
            dpiq_pkg::S_WALK:  o_cmd.walk_adv = !i_sts.walk_stop;
            dpiq_pkg::S_LINK:  o_cmd.ins_link = 1'b1;
            dpiq_pkg::S_FIX:   o_cmd.ins_fix  = !i_sts.out_vld;
            dpiq_pkg::S_TCHK: begin
                if (i_sts.due_ok) o_cmd.pop = !(i_sts.hold_vld && i_sts.out_vld);
                else o_cmd.flush = i_sts.hold_vld && !i_sts.out_vld;
            end
            dpiq_pkg::S_TEND:  o_cmd.flush = !i_sts.out_vld;
            default: o_cmd = '0;
        endcase
    end

endmodule

[src/dpiq_dp.sv]
// ----------------------------------------------------------------------------
// dpiq_dp
// Datapath: configuration, entry memories, linked lists, counters, result.
// ----------------------------------------------------------------------------
module dpiq_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dpiq_pkg::t_cmd                    i_cmd,
    output dpiq_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_valid,
    input  logic [dpiq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpiq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_opcode,
    input  logic [31:0]                       i_now_time,
    input  logic [15:0]                       i_rand_drop,
    input  logic [15:0]                       i_rand_jitter,
    input  logic [15:0]                       i_packet_handle,
    input  logic [31:0]                       i_src_addr,
    input  logic [15:0]                       i_src_port,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [1:0]                        o_result_kind,
    output logic [15:0]                       o_out_handle,
    output logic [31:0]                       o_out_addr,
    output logic [15:0]                       o_out_port,
    output logic                              o_last_result,
    output logic [5:0]                        o_pending_count,
    output logic [31:0]                       o_delivered_total,
    output logic [31:0]                       o_dropped_total
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LW-1:0] NONE = LW'(QUEUE_DEPTH);
    localparam logic [5:0] LAST_N = 6'(dpiq_pkg::MAX_RESULTS - 1);

    // configuration
    logic        r_drop_en, r_lat_en;
    logic [16:0] r_thr;
    logic [19:0] r_lat, r_jit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_en <= 1'b0;
            r_lat_en  <= 1'b0;
            r_thr     <= 17'd655;
            r_lat     <= 20'd70000;
            r_jit     <= 20'd30000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dpiq_pkg::CFG_DROP_EN:  r_drop_en <= i_cfg_data[0];
                dpiq_pkg::CFG_LAT_EN:   r_lat_en  <= i_cfg_data[0];
                dpiq_pkg::CFG_DROP_THR: r_thr     <= i_cfg_data[16:0];
                dpiq_pkg::CFG_LATENCY:  r_lat     <= i_cfg_data;
                dpiq_pkg::CFG_JITTER:   r_jit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic        r_op;
    logic [31:0] r_now, r_adr;
    logic [15:0] r_rdrop, r_rjit, r_hdl, r_prt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_opcode;
            r_now   <= i_now_time;
            r_rdrop <= i_rand_drop;
            r_rjit  <= i_rand_jitter;
            r_hdl   <= i_packet_handle;
            r_adr   <= i_src_addr;
            r_prt   <= i_src_port;
        end
    end

    // memories and read port
    logic [31:0]   due_mem [QUEUE_DEPTH];
    logic [15:0]   hdl_mem [QUEUE_DEPTH];
    logic [31:0]   adr_mem [QUEUE_DEPTH];
    logic [15:0]   prt_mem [QUEUE_DEPTH];
    logic [LW-1:0] lnk_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_lvld;

    logic [31:0]   r_due_q, r_adr_q;
    logic [15:0]   r_hdl_q, r_prt_q;
    logic [LW-1:0] r_lnk_q;
    logic          r_lvld_q;
    logic [IW-1:0] r_rda_q;

    logic          w_rd_en;
    logic [LW-1:0] w_rd_addr;
    logic          w_lw_en;
    logic [IW-1:0] w_lw_addr;
    logic [LW-1:0] w_lw_data;
    logic [LW-1:0] w_link_rd;

    // control state
    logic [LW-1:0] r_head, r_free, r_count, r_x, r_prev;
    logic [IW-1:0] r_slot;
    logic [31:0]   r_deliv, r_drops, r_due;
    logic [20:0]   r_prod;
    logic [5:0]    r_n;

    // hold and output
    logic        r_h_vld;
    logic [15:0] r_h_hdl, r_h_prt;
    logic [31:0] r_h_adr, r_h_dlv, r_h_drp;
    logic [LW-1:0] r_h_cnt;

    logic        r_o_vld, r_o_last;
    logic [1:0]  r_o_kind;
    logic [15:0] r_o_hdl, r_o_prt;
    logic [31:0] r_o_adr, r_o_dlv, r_o_drp;
    logic [LW-1:0] r_o_cnt;

    logic [LW-1:0] w_cnt_dec;
    logic [7:0]    w_cnt8;

    assign w_link_rd = r_lvld_q ? r_lnk_q : (LW'(r_rda_q) + LW'(1));
    assign w_cnt_dec = (r_count != '0) ? (r_count - LW'(1)) : r_count;

    // read address select
    always_comb begin
        w_rd_addr = NONE;
        if (i_cmd.start_ins) w_rd_addr = r_free;
        if (i_cmd.free_adv || i_cmd.tick_start) w_rd_addr = r_head;
        if (i_cmd.walk_adv || i_cmd.pop) w_rd_addr = w_link_rd;
        w_rd_en = (w_rd_addr < NONE);
    end

    // link write select
    always_comb begin
        w_lw_en   = 1'b0;
        w_lw_addr = r_slot;
        w_lw_data = r_x;
        if (i_cmd.ins_link) begin
            w_lw_en = 1'b1;
        end
        if (i_cmd.ins_fix && (r_prev < NONE)) begin
            w_lw_en   = 1'b1;
            w_lw_addr = r_prev[IW-1:0];
            w_lw_data = LW'(r_slot);
        end
        if (i_cmd.pop) begin
            w_lw_en   = 1'b1;
            w_lw_addr = r_head[IW-1:0];
            w_lw_data = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_link) begin
            due_mem[r_slot] <= r_due;
            hdl_mem[r_slot] <= r_hdl;
            adr_mem[r_slot] <= r_adr;
            prt_mem[r_slot] <= r_prt;
        end
        if (w_lw_en) lnk_mem[w_lw_addr] <= w_lw_data;
        if (w_rd_en) begin
            r_due_q  <= due_mem[w_rd_addr[IW-1:0]];
            r_hdl_q  <= hdl_mem[w_rd_addr[IW-1:0]];
            r_adr_q  <= adr_mem[w_rd_addr[IW-1:0]];
            r_prt_q  <= prt_mem[w_rd_addr[IW-1:0]];
            r_lnk_q  <= lnk_mem[w_rd_addr[IW-1:0]];
            r_lvld_q <= r_lvld[w_rd_addr[IW-1:0]];
            r_rda_q  <= w_rd_addr[IW-1:0];
        end
    end

    // link entries never written read as the index-order chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
        end else if (w_lw_en) begin
            r_lvld[w_lw_addr] <= 1'b1;
        end
    end

    // list heads, counters, walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NONE;
            r_free  <= '0;
            r_count <= '0;
            r_deliv <= '0;
            r_drops <= '0;
            r_h_vld <= 1'b0;
            r_n     <= '0;
        end else begin
            if (i_cmd.out_bypass) r_deliv <= r_deliv + 32'd1;
            if (i_cmd.out_drop)   r_drops <= r_drops + 32'd1;
            if (i_cmd.start_ins) begin
                r_slot <= r_free[IW-1:0];
                r_prod <= 21'((36'(r_jit) * 36'(r_rjit)) >> 15);
            end
            if (i_cmd.free_adv) begin
                r_free <= (w_link_rd < NONE) ? w_link_rd : NONE;
                r_due  <= r_lat_en ? (r_now + 32'(r_lat) + 32'(r_prod) - 32'(r_jit)) : r_now;
                r_x    <= r_head;
                r_prev <= NONE;
            end
            if (i_cmd.walk_adv) begin
                r_prev <= r_x;
                r_x    <= (w_link_rd < NONE) ? w_link_rd : NONE;
            end
            if (i_cmd.ins_fix) begin
                if (r_prev >= NONE) r_head <= LW'(r_slot);
                r_count <= r_count + LW'(1);
            end
            if (i_cmd.tick_start) begin
                r_n     <= '0;
                r_h_vld <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_head  <= (w_link_rd < NONE) ? w_link_rd : NONE;
                r_free  <= r_head;
                r_count <= w_cnt_dec;
                r_deliv <= r_deliv + 32'd1;
                r_n     <= r_n + 6'd1;
                r_h_vld <= 1'b1;
            end
            if (i_cmd.flush) r_h_vld <= 1'b0;
        end
    end

    // held result of the last pop, sent on the next pop or on the flush that ends the tick
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_h_hdl <= r_hdl_q;
            r_h_adr <= r_adr_q;
            r_h_prt <= r_prt_q;
            r_h_cnt <= w_cnt_dec;
            r_h_dlv <= r_deliv + 32'd1;
            r_h_drp <= r_drops;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            if (r_o_vld && i_out_ready) r_o_vld <= 1'b0;
            if (i_cmd.out_bypass || i_cmd.out_drop || i_cmd.out_reject || i_cmd.ins_fix
                || i_cmd.flush || (i_cmd.pop && r_h_vld)) begin
                r_o_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_bypass || i_cmd.out_drop || i_cmd.out_reject || i_cmd.ins_fix) begin
            r_o_hdl  <= r_hdl;
            r_o_adr  <= r_adr;
            r_o_prt  <= r_prt;
            r_o_last <= 1'b1;
            r_o_cnt  <= r_count;
            r_o_dlv  <= r_deliv;
            r_o_drp  <= r_drops;
            r_o_kind <= dpiq_pkg::KIND_REJECTED;
            if (i_cmd.out_bypass) begin
                r_o_kind <= dpiq_pkg::KIND_DELIVERED;
                r_o_dlv  <= r_deliv + 32'd1;
            end
            if (i_cmd.out_drop) begin
                r_o_kind <= dpiq_pkg::KIND_DROPPED;
                r_o_drp  <= r_drops + 32'd1;
            end
            if (i_cmd.ins_fix) begin
                r_o_kind <= dpiq_pkg::KIND_QUEUED;
                r_o_cnt  <= r_count + LW'(1);
            end
        end
        if (i_cmd.flush || (i_cmd.pop && r_h_vld)) begin
            r_o_kind <= dpiq_pkg::KIND_DELIVERED;
            r_o_hdl  <= r_h_hdl;
            r_o_adr  <= r_h_adr;
            r_o_prt  <= r_h_prt;
            r_o_last <= i_cmd.flush;
            r_o_cnt  <= r_h_cnt;
            r_o_dlv  <= r_h_dlv;
            r_o_drp  <= r_h_drp;
        end
    end

    assign w_cnt8            = 8'(r_o_cnt);
    assign o_out_valid       = r_o_vld;
    assign o_result_kind     = r_o_kind;
    assign o_out_handle      = r_o_hdl;
    assign o_out_addr        = r_o_adr;
    assign o_out_port        = r_o_prt;
    assign o_last_result     = r_o_last;
    assign o_pending_count   = w_cnt8[5:0];
    assign o_delivered_total = r_o_dlv;
    assign o_dropped_total   = r_o_drp;

    // status
    always_comb begin
        o_sts           = '0;
        o_sts.is_tick   = r_op;
        o_sts.bypass    = !r_drop_en && !r_lat_en;
        o_sts.frozen    = !r_drop_en && !r_lat_en;
        o_sts.drop      = r_drop_en && (17'(r_rdrop) <= r_thr);
        o_sts.full      = (r_free >= NONE) || (r_count >= NONE);
        o_sts.out_vld   = r_o_vld;
        o_sts.head_none = (r_head >= NONE);
        o_sts.walk_stop = dpiq_pkg::is_after(r_due_q, r_due);
        o_sts.link_none = (w_link_rd >= NONE);
        o_sts.due_ok    = !dpiq_pkg::is_after(r_due_q, r_now);
        o_sts.hold_vld  = r_h_vld;
        o_sts.pop_last  = (w_link_rd >= NONE) || (r_n == LAST_N);
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NONE)
        else $error("queued count beyond depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins_fix || i_cmd.flush || i_cmd.out_bypass) |-> !r_o_vld)
        else $error("result loaded over a pending result");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_fix |=> (r_count == $past(r_count) + LW'(1)))
        else $error("insert did not advance queued count");

    a_pop_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_n <= LAST_N))
        else $error("too many packets drained in one tick");

endmodule

[src/delayed_packet_impairment_queue_top.sv]
// ----------------------------------------------------------------------------
// delayed_packet_impairment_queue_top
// Network impairment emulator: drop, delay and jitter with a sorted queue.
// ----------------------------------------------------------------------------
// Arrive item: a pass, drop or reject result is loaded from the decide state; a queued
//   result follows the free-list step, the walk over the list, then the link and fix steps.
// Tick item: drains due packets from the head of the queue, 32 packets at most;
//   no result when the queue is empty or frozen. A stalled result holds the sequencer.
// One item at a time; a new item is taken only in the idle state, after the last one.
// Synchronous active-low reset: empty queue, counters zero, default settings.
module delayed_packet_impairment_queue_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // arrive / tick items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [31:0]                       i_now_time,
    input  logic [15:0]                       i_rand_drop,
    input  logic [15:0]                       i_rand_jitter,
    input  logic [15:0]                       i_packet_handle,
    input  logic [31:0]                       i_src_addr,
    input  logic [15:0]                       i_src_port,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_result_kind,
    output logic [15:0]                       o_out_handle,
    output logic [31:0]                       o_out_addr,
    output logic [15:0]                       o_out_port,
    output logic                              o_last_result,
    output logic [5:0]                        o_pending_count,
    output logic [31:0]                       o_delivered_total,
    output logic [31:0]                       o_dropped_total,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dpiq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dpiq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dpiq_pkg::t_cmd w_cmd;
    dpiq_pkg::t_sts w_sts;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts an item only when idle, then steps the datapath
    dpiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: entry memories, free and pending lists, result register
    dpiq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_now_time        (i_now_time),
        .i_rand_drop       (i_rand_drop),
        .i_rand_jitter     (i_rand_jitter),
        .i_packet_handle   (i_packet_handle),
        .i_src_addr        (i_src_addr),
        .i_src_port        (i_src_port),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_out_handle      (o_out_handle),
        .o_out_addr        (o_out_addr),
        .o_out_port        (o_out_port),
        .o_last_result     (o_last_result),
        .o_pending_count   (o_pending_count),
        .o_delivered_total (o_delivered_total),
        .o_dropped_total   (o_dropped_total)
    );

endmodule
